>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rps_pkg.sv
package rps_pkg;

   typedef logic [1:0] stage_type;
   typedef logic [1:0] event_type;

   localparam int TGT_W   = 9;
   localparam int HOLD_W  = 16;
   localparam int TEMP_W  = 14;
   localparam int TENTH_W = 15;   // signed tenths, holds target*10 +/- margins
   localparam int SECS_W  = 22;
   localparam int DUTY_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // now_ms / 1000 == (now_ms * MS_DIV_MAGIC) >> MS_DIV_SHIFT for any 32-bit value
   localparam int MS_W         = 32;
   localparam int MAGIC_W      = 29;
   localparam int PROD_W       = MS_W + MAGIC_W;
   localparam logic [MAGIC_W-1:0] MS_DIV_MAGIC = 29'd274877907;
   localparam int MS_DIV_SHIFT = 38;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PREHEAT_TARGET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PREHEAT_HOLD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOAK_TARGET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOAK_HOLD      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_TARGET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_HOLD      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COOL_TARGET    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COOL_HOLD      = 3'd7;

   // Register reset values
   localparam logic [TGT_W-1:0]  RST_PREHEAT_TARGET = 9'd130;
   localparam logic [HOLD_W-1:0] RST_PREHEAT_HOLD   = 16'd1;
   localparam logic [TGT_W-1:0]  RST_SOAK_TARGET    = 9'd130;
   localparam logic [HOLD_W-1:0] RST_SOAK_HOLD      = 16'd99;
   localparam logic [TGT_W-1:0]  RST_PEAK_TARGET    = 9'd170;
   localparam logic [HOLD_W-1:0] RST_PEAK_HOLD      = 16'd36;
   localparam logic [TGT_W-1:0]  RST_COOL_TARGET    = 9'd80;
   localparam logic [HOLD_W-1:0] RST_COOL_HOLD      = 16'd20;

   localparam stage_type STG_PREHEAT = 2'd0;
   localparam stage_type STG_SOAK    = 2'd1;
   localparam stage_type STG_REFLOW  = 2'd2;
   localparam stage_type STG_COOL    = 2'd3;

   localparam event_type EV_PROCEED   = 2'd0;
   localparam event_type EV_NEW_STAGE = 2'd1;
   localparam event_type EV_STOP      = 2'd2;

   localparam logic signed [TENTH_W-1:0] PRECISION_TENTHS = 15'sd50;
   localparam logic signed [TENTH_W-1:0] FAN_HI_MARGIN    = 15'sd110;
   localparam logic signed [TENTH_W-1:0] FAN_MID_MARGIN   = 15'sd90;
   localparam logic signed [TENTH_W-1:0] FAN_LO_MARGIN    = 15'sd40;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
   localparam logic [DUTY_W-1:0] DUTY_HIGH = 7'd70;
   localparam logic [DUTY_W-1:0] DUTY_LOW  = 7'd50;
   localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd0;

   // Whole degrees to tenths: t*8 + t*2
   function automatic logic signed [TENTH_W-1:0] to_tenths(input logic [TGT_W-1:0] t);
      logic [TENTH_W-1:0] ext;
      ext = TENTH_W'(t);
      return $signed((ext << 3) + (ext << 1));
   endfunction

endpackage

>>> src/reflow_profile_sequencer.sv
// A req word accepted into stage one passes on to the result register, where its
// rsp word is valid; rsp_stall holds it there and the next word in stage one.
// Throughput: 1 word per cycle unless rsp_stall holds; stage one registers the
// ms-to-seconds multiply, stage two updates profile state and the result register.
// Reset (synchronous, active high): profile back to preheat, first sample flagged,
// all pipeline valids cleared, stage registers back to their default values.
`include "assert_macros.svh"

module reflow_profile_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [rps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [rps_pkg::MS_W-1:0]            req_now_ms,
   input  logic signed [rps_pkg::TEMP_W-1:0]   req_board_temp,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rps_pkg::TGT_W-1:0]           rsp_target_temp,
   output logic [1:0]                          rsp_event_res,
   output logic [1:0]                          rsp_stage,
   output logic                                rsp_heat_allowed,
   output logic [rps_pkg::DUTY_W-1:0]          rsp_fan_duty
);

   // ---------------------------------------------------------------
   // Stage registers (per-stage target and hold time)
   // ---------------------------------------------------------------
   logic [rps_pkg::TGT_W-1:0]  preheat_target_ff, soak_target_ff;
   logic [rps_pkg::TGT_W-1:0]  peak_target_ff, cool_target_ff;
   logic [rps_pkg::HOLD_W-1:0] preheat_hold_ff, soak_hold_ff;
   logic [rps_pkg::HOLD_W-1:0] peak_hold_ff, cool_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         preheat_target_ff <= rps_pkg::RST_PREHEAT_TARGET;
         preheat_hold_ff   <= rps_pkg::RST_PREHEAT_HOLD;
         soak_target_ff    <= rps_pkg::RST_SOAK_TARGET;
         soak_hold_ff      <= rps_pkg::RST_SOAK_HOLD;
         peak_target_ff    <= rps_pkg::RST_PEAK_TARGET;
         peak_hold_ff      <= rps_pkg::RST_PEAK_HOLD;
         cool_target_ff    <= rps_pkg::RST_COOL_TARGET;
         cool_hold_ff      <= rps_pkg::RST_COOL_HOLD;
      end else if (csr_wr_en) begin
         case (csr_index)
            rps_pkg::REG_PREHEAT_TARGET: preheat_target_ff <= csr_wdata[rps_pkg::TGT_W-1:0];
            rps_pkg::REG_PREHEAT_HOLD:   preheat_hold_ff   <= csr_wdata;
            rps_pkg::REG_SOAK_TARGET:    soak_target_ff    <= csr_wdata[rps_pkg::TGT_W-1:0];
            rps_pkg::REG_SOAK_HOLD:      soak_hold_ff      <= csr_wdata;
            rps_pkg::REG_PEAK_TARGET:    peak_target_ff    <= csr_wdata[rps_pkg::TGT_W-1:0];
            rps_pkg::REG_PEAK_HOLD:      peak_hold_ff      <= csr_wdata;
            rps_pkg::REG_COOL_TARGET:    cool_target_ff    <= csr_wdata[rps_pkg::TGT_W-1:0];
            rps_pkg::REG_COOL_HOLD:      cool_hold_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake / pipeline control
   //   s1 holds one word; it also serves as the skid slot while the
   //   result register waits on rsp_stall.
   // ---------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load;
   logic req_accept;

   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !rsp_load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: seconds = now_ms / 1000 by reciprocal multiply (exact over the full
   // 32-bit range, kept as the low 22 bits); temperature and mode ride along.
   // ---------------------------------------------------------------
   logic [rps_pkg::PROD_W-1:0]        div_prod;
   logic                              s1_mode_ff;
   logic [rps_pkg::SECS_W-1:0]        s1_secs_ff;
   logic signed [rps_pkg::TEMP_W-1:0] s1_temp_ff;

   assign div_prod = rps_pkg::PROD_W'(req_now_ms) * rps_pkg::PROD_W'(rps_pkg::MS_DIV_MAGIC);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff <= req_mode;
         s1_secs_ff <= div_prod[rps_pkg::MS_DIV_SHIFT +: rps_pkg::SECS_W];
         s1_temp_ff <= req_board_temp;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: profile state
   // ---------------------------------------------------------------
   rps_pkg::stage_type        stage_ff, stage_in;
   logic                      reached_ff, reached_in;
   logic [rps_pkg::SECS_W-1:0] hold_start_ff, hold_start_in;
   logic                      fresh_ff, fresh_in;

   rps_pkg::stage_type        stage_nxt;
   logic [rps_pkg::TGT_W-1:0]  tgt_cur, tgt_nxt, tgt_out;
   logic [rps_pkg::HOLD_W-1:0] hold_cur;
   logic [rps_pkg::SECS_W-1:0] held;
   logic                      hold_done;
   logic                      hit;
   logic signed [rps_pkg::TENTH_W-1:0] temp_x, t10_cur, t10_out;
   rps_pkg::event_type        ev;

   logic [rps_pkg::TGT_W-1:0]  rsp_target_ff, rsp_target_in;
   rps_pkg::event_type        rsp_event_ff, rsp_event_in;
   rps_pkg::stage_type        rsp_stage_ff, rsp_stage_in;
   logic                      rsp_heat_ff, rsp_heat_in;
   logic [rps_pkg::DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;

   assign stage_nxt = stage_ff + 2'd1;

   always_comb begin
      case (stage_ff)
         rps_pkg::STG_PREHEAT: begin tgt_cur = preheat_target_ff; hold_cur = preheat_hold_ff; end
         rps_pkg::STG_SOAK:    begin tgt_cur = soak_target_ff;    hold_cur = soak_hold_ff;    end
         rps_pkg::STG_REFLOW:  begin tgt_cur = peak_target_ff;    hold_cur = peak_hold_ff;    end
         default:              begin tgt_cur = cool_target_ff;    hold_cur = cool_hold_ff;    end
      endcase
      case (stage_nxt)
         rps_pkg::STG_PREHEAT: tgt_nxt = preheat_target_ff;
         rps_pkg::STG_SOAK:    tgt_nxt = soak_target_ff;
         rps_pkg::STG_REFLOW:  tgt_nxt = peak_target_ff;
         default:              tgt_nxt = cool_target_ff;
      endcase
   end

   // hold time wraps modulo 2^22, so time going back reads as a long hold
   assign held      = s1_secs_ff - hold_start_ff;
   assign hold_done = held >= rps_pkg::SECS_W'(hold_cur);

   assign temp_x  = rps_pkg::TENTH_W'(s1_temp_ff);
   assign t10_cur = rps_pkg::to_tenths(tgt_cur);

   // cooling: at or below target; heating stages: inside the window
   assign hit = (stage_ff == rps_pkg::STG_COOL) ? (temp_x <= t10_cur) :
                ((temp_x >= t10_cur - rps_pkg::PRECISION_TENTHS) &&
                 (temp_x <= t10_cur + rps_pkg::PRECISION_TENTHS));

   always_comb begin
      stage_in      = stage_ff;
      reached_in    = reached_ff;
      hold_start_in = hold_start_ff;
      fresh_in      = fresh_ff;
      ev            = rps_pkg::EV_PROCEED;
      tgt_out       = tgt_cur;

      if (reached_ff) begin
         if (hold_done) begin
            if (stage_ff == rps_pkg::STG_COOL) begin
               ev = rps_pkg::EV_STOP;
            end else begin
               stage_in   = stage_nxt;
               reached_in = 1'b0;
               tgt_out    = tgt_nxt;
               ev         = rps_pkg::EV_NEW_STAGE;
            end
         end
      end else if (hit) begin
         reached_in    = 1'b1;
         hold_start_in = s1_secs_ff;
      end

      // first non-restart sample after reset or restart flags a new stage
      if (fresh_ff) begin
         fresh_in = 1'b0;
         ev       = rps_pkg::EV_NEW_STAGE;
      end

      t10_out = rps_pkg::to_tenths(tgt_out);

      rsp_target_in = tgt_out;
      rsp_event_in  = ev;
      rsp_stage_in  = stage_in;
      if (ev == rps_pkg::EV_STOP) begin
         rsp_heat_in = 1'b0;
         rsp_duty_in = rps_pkg::DUTY_OFF;
      end else begin
         rsp_heat_in = (stage_in != rps_pkg::STG_COOL);
         if (temp_x > t10_out + rps_pkg::FAN_HI_MARGIN) begin
            rsp_duty_in = rps_pkg::DUTY_FULL;
         end else if (temp_x > t10_out + rps_pkg::FAN_MID_MARGIN) begin
            rsp_duty_in = rps_pkg::DUTY_HIGH;
         end else if (temp_x > t10_out + rps_pkg::FAN_LO_MARGIN) begin
            rsp_duty_in = rps_pkg::DUTY_LOW;
         end else begin
            rsp_duty_in = rps_pkg::DUTY_OFF;
         end
      end

      // restart: back to preheat, sample ignored
      if (s1_mode_ff) begin
         stage_in      = rps_pkg::STG_PREHEAT;
         reached_in    = 1'b0;
         hold_start_in = '0;
         fresh_in      = 1'b1;
         rsp_target_in = preheat_target_ff;
         rsp_event_in  = rps_pkg::EV_PROCEED;
         rsp_stage_in  = rps_pkg::STG_PREHEAT;
         rsp_heat_in   = 1'b1;
         rsp_duty_in   = rps_pkg::DUTY_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= rps_pkg::STG_PREHEAT;
         reached_ff    <= 1'b0;
         hold_start_ff <= '0;
         fresh_ff      <= 1'b1;
      end else if (rsp_load) begin
         stage_ff      <= stage_in;
         reached_ff    <= reached_in;
         hold_start_ff <= hold_start_in;
         fresh_ff      <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_target_ff <= rsp_target_in;
         rsp_event_ff  <= rsp_event_in;
         rsp_stage_ff  <= rsp_stage_in;
         rsp_heat_ff   <= rsp_heat_in;
         rsp_duty_ff   <= rsp_duty_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_temp  = rsp_target_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_stage        = rsp_stage_ff;
   assign rsp_heat_allowed = rsp_heat_ff;
   assign rsp_fan_duty     = rsp_duty_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_IMPLIES(a_stop_shape, clock, reset,
      rsp_valid_ff && (rsp_event_ff == rps_pkg::EV_STOP),
      (rsp_stage_ff == rps_pkg::STG_COOL) && !rsp_heat_ff && (rsp_duty_ff == rps_pkg::DUTY_OFF),
      "stop word must report cooling, no heat, fan off")
   `ASSERT_IMPLIES(a_heat_stage, clock, reset,
      rsp_valid_ff && (rsp_event_ff != rps_pkg::EV_STOP),
      rsp_heat_ff == (rsp_stage_ff != rps_pkg::STG_COOL),
      "heat_allowed disagrees with stage")
   `ASSERT_IMPLIES(a_fresh_idle, clock, reset,
      fresh_ff,
      !reached_ff && (stage_ff == rps_pkg::STG_PREHEAT),
      "fresh start with profile not at preheat")
   `ASSERT_NEXT(a_restart, clock, reset,
      rsp_load && s1_mode_ff,
      fresh_ff && !reached_ff && (stage_ff == rps_pkg::STG_PREHEAT) &&
         (rsp_event_ff == rps_pkg::EV_PROCEED),
      "restart word did not reset the profile")

endmodule
